>>> rtl/npcs_pkg.sv
// shared constants, types and codes for the nearest palette color search block
// no dependencies; compiled first

package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

   localparam int CHAN_W = 8;
   localparam int INDEX_W = 8;
   localparam int SCORE_W = 8;
   localparam int ENTRY_W = 3 * CHAN_W;
   localparam int SUM_W = 10;

   // x / 3 == (x * 683) >> 11 for every x below 768
   localparam int DIV3_MUL_W = 10;
   localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = DIV3_MUL_W'(683);
   localparam int DIV3_SHIFT = 11;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [INDEX_W-1:0] INDEX_NONE = '1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } npcs_state_type;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic rsp_load;
   } npcs_cmd_type;

   typedef struct packed {
      logic issued_all;
      logic pipe_empty;
      logic best_zero;
      logic rsp_free;
   } npcs_sts_type;

endpackage

>>> rtl/npcs_req_if.sv
// request channel: palette write or nearest color query
// depends on npcs_pkg

interface npcs_req_if;
   import npcs_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [INDEX_W-1:0] entry_index;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;
   logic               load_last;

   modport source (
      output valid, cmd, entry_index, red, green, blue, load_last,
      input  ready
   );

   modport sink (
      input  valid, cmd, entry_index, red, green, blue, load_last,
      output ready
   );
endinterface

>>> rtl/npcs_rsp_if.sv
// response channel: chosen index, score and load marker echo
// depends on npcs_pkg

interface npcs_rsp_if;
   import npcs_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] color_index;
   logic [SCORE_W-1:0] best_score;
   logic               load_done;

   modport source (
      output valid, color_index, best_score, load_done,
      input  ready
   );

   modport sink (
      input  valid, color_index, best_score, load_done,
      output ready
   );
endinterface

>>> rtl/npcs_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module npcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/npcs_ctrl.sv
// controller: sequences request intake, palette scan and response hand-off
// depends on npcs_pkg

module npcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   input  npcs_pkg::npcs_sts_type sts,
   output npcs_pkg::npcs_cmd_type cmd
);
   import npcs_pkg::*;

   npcs_state_type state_ff;
   npcs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_cmd == CMD_QUERY) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // a zero score can never be beaten, so the scan ends there
            if (sts.best_zero || (sts.issued_all && sts.pipe_empty)) begin
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = !sts.issued_all;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/npcs_dp.sv
// datapath: palette store, scoring pipeline, best tracker and response register
// depends on npcs_pkg and npcs_ram

module npcs_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  npcs_pkg::npcs_cmd_type      cmd,
   output npcs_pkg::npcs_sts_type      sts,
   input  logic                        req_cmd,
   input  logic [npcs_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [npcs_pkg::CHAN_W-1:0] req_red,
   input  logic [npcs_pkg::CHAN_W-1:0] req_green,
   input  logic [npcs_pkg::CHAN_W-1:0] req_blue,
   input  logic                        req_load_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [npcs_pkg::INDEX_W-1:0] rsp_color_index,
   output logic [npcs_pkg::SCORE_W-1:0] rsp_best_score,
   output logic                        rsp_load_done
);
   import npcs_pkg::*;

   // latched request
   logic               query_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [CHAN_W-1:0]  red_ff;
   logic [CHAN_W-1:0]  green_ff;
   logic [CHAN_W-1:0]  blue_ff;
   logic               last_ff;

   // palette write and per-entry written flags
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [PALETTE_ENTRIES-1:0] written_ff;
   logic [PALETTE_ENTRIES-1:0] written_in;

   // scan pipeline
   logic [CNT_W-1:0]   count_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               rd_vld_ff;
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic               rd_written_ff;
   logic [ENTRY_W-1:0] entry;
   logic [CHAN_W-1:0]  diff_r;
   logic [CHAN_W-1:0]  diff_g;
   logic [CHAN_W-1:0]  diff_b;
   logic               sum_vld_ff;
   logic [ADDR_W-1:0]  sum_idx_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W+DIV3_MUL_W-1:0] prod;
   logic               score_vld_ff;
   logic [ADDR_W-1:0]  score_idx_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [SCORE_W-1:0] best_ff;
   logic [INDEX_W-1:0] chosen_ff;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_last_ff;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign wr_en   = cmd.accept && (req_cmd == CMD_WRITE)
                    && (32'(req_entry_index) < PALETTE_ENTRIES);
   assign wr_addr = ADDR_W'(req_entry_index);
   assign rd_addr = count_ff[ADDR_W-1:0];

   npcs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_palette (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({req_red, req_green, req_blue}),
      .rd_en  (cmd.scan_step),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         query_ff <= (req_cmd == CMD_QUERY);
         index_ff <= req_entry_index;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         last_ff  <= req_load_last;
      end
   end

   // an entry never written reads as black, as after reset
   assign entry  = rd_written_ff ? rd_data : '0;
   assign diff_r = abs_diff(entry[3*CHAN_W-1:2*CHAN_W], red_ff);
   assign diff_g = abs_diff(entry[2*CHAN_W-1:CHAN_W], green_ff);
   assign diff_b = abs_diff(entry[CHAN_W-1:0], blue_ff);
   assign prod   = (SUM_W + DIV3_MUL_W)'(sum_ff) * (SUM_W + DIV3_MUL_W)'(DIV3_MUL);

   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         sum_vld_ff   <= 1'b0;
         score_vld_ff <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            count_ff <= count_ff + 1'b1;
         end
         rd_vld_ff    <= cmd.scan_step;
         sum_vld_ff   <= rd_vld_ff;
         score_vld_ff <= sum_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_addr;
      rd_written_ff <= written_ff[rd_addr];
      sum_idx_ff    <= rd_idx_ff;
      sum_ff        <= SUM_W'(diff_r) + SUM_W'(diff_g) + SUM_W'(diff_b);
      score_idx_ff  <= sum_idx_ff;
      score_ff      <= SCORE_W'(prod >> DIV3_SHIFT);
   end

   // strict compare keeps the first index among equal scores
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         best_ff   <= SCORE_MAX;
         chosen_ff <= INDEX_NONE;
      end else if (score_vld_ff && (score_ff < best_ff)) begin
         best_ff   <= score_ff;
         chosen_ff <= INDEX_W'(score_idx_ff);
      end
   end

   assign sts.issued_all = (32'(count_ff) == PALETTE_ENTRIES);
   assign sts.pipe_empty = !rd_vld_ff && !sum_vld_ff && !score_vld_ff;
   assign sts.best_zero  = (best_ff == '0);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (query_ff) begin
            rsp_index_ff <= chosen_ff;
            rsp_score_ff <= best_ff;
            rsp_last_ff  <= 1'b0;
         end else begin
            rsp_index_ff <= index_ff;
            rsp_score_ff <= '0;
            rsp_last_ff  <= last_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;
   assign rsp_best_score  = rsp_score_ff;
   assign rsp_load_done   = rsp_last_ff;

endmodule

>>> rtl/nearest_palette_color_search.sv
// channel  | dir | handshake     | payload
// req_ch   | in  | valid / ready | cmd, entry_index, red, green, blue, load_last
// rsp_ch   | out | valid / ready | color_index, best_score, load_done
//
// a write request goes from acceptance through the finish state to a loaded response register
// a query makes one palette read per cycle from the single read port, followed
// by a three stage scoring drain;
// it ends early once an entry scores zero
// reset is synchronous; it clears the written flags, so every entry reads as zero
// a response waits in its own register while rsp_ch stalls; the next request is
// accepted meanwhile and finishing stalls only if that register is still full
//
// depends on npcs_pkg, npcs_req_if, npcs_rsp_if, npcs_ctrl, npcs_dp

module nearest_palette_color_search (
   input logic        clock,
   input logic        reset,
   npcs_req_if.sink   req_ch,
   npcs_rsp_if.source rsp_ch
);
   import npcs_pkg::*;

   npcs_cmd_type cmd;
   npcs_sts_type sts;

   npcs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_cmd  (req_ch.cmd),
      .req_ready(req_ch.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   npcs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_cmd        (req_ch.cmd),
      .req_entry_index(req_ch.entry_index),
      .req_red        (req_ch.red),
      .req_green      (req_ch.green),
      .req_blue       (req_ch.blue),
      .req_load_last  (req_ch.load_last),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_color_index(rsp_ch.color_index),
      .rsp_best_score (rsp_ch.best_score),
      .rsp_load_done  (rsp_ch.load_done)
   );

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   // the response register is never overwritten while it holds an untaken response
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response register overwritten");

   // the read counter never runs past the palette
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !sts.issued_all)
      else $error("palette read beyond last entry");

   // a write response with load_done set carries a zero score
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.load_done) |-> (rsp_ch.best_score == '0))
      else $error("write response with nonzero score");

endmodule
